// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the averaging voltmeter display block.
// Depends on nothing; the asserting module must provide i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_PROP(label, !(expr), msg)
`else
`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

// ----- src/adcvm_pkg.sv -----
// Package for the averaging voltmeter display block: field widths, scaling
// constants, the result struct and the digit conversion functions. No dependencies.
`timescale 1ns / 1ps

package adcvm_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int SEG_W       = 7;
    localparam int BCD_W       = 8;
    localparam int TENTHS_W    = 6;
    localparam int SCALED_W    = 16;
    localparam int SCALE_NUM   = 33;
    localparam int SCALE_ROUND = 511;
    localparam int FULL_SH     = 10;
    localparam int S_DATA_W    = 16;
    localparam int M_DATA_W    = 16;

    typedef struct packed {
        logic [SEG_W-1:0] segments;
        logic             low_digit_on;
        logic             high_digit_on;
    } t_disp_out;

    function automatic logic [SEG_W-1:0] seg_glyph(input logic [3:0] nib);
        logic [SEG_W-1:0] g;
        unique case (nib)
            4'h0: g = 7'h3F;
            4'h1: g = 7'h06;
            4'h2: g = 7'h5B;
            4'h3: g = 7'h4F;
            4'h4: g = 7'h66;
            4'h5: g = 7'h6D;
            4'h6: g = 7'h7D;
            4'h7: g = 7'h07;
            4'h8: g = 7'h7F;
            4'h9: g = 7'h6F;
            4'hA: g = 7'h77;
            4'hB: g = 7'h7C;
            4'hC: g = 7'h39;
            4'hD: g = 7'h5E;
            4'hE: g = 7'h79;
            default: g = 7'h71;
        endcase
        return g;
    endfunction

    function automatic logic [BCD_W-1:0] to_bcd(input logic [TENTHS_W-1:0] v);
        logic [3:0]          tens;
        logic [TENTHS_W-1:0] units;
        tens = 4'd0;
        for (int k = 1; k <= 6; k++) begin
            if (v >= TENTHS_W'(10 * k)) begin
                tens = 4'(k);
            end
        end
        units = v - TENTHS_W'(tens) * TENTHS_W'(10);
        return {tens, units[3:0]};
    endfunction

endpackage

// ----- src/adcvm_average.sv -----
// Sample accumulator with mean, scaling to tenths of a volt and BCD conversion.
// Depends on adcvm_pkg.
`timescale 1ns / 1ps

module adcvm_average #(
    parameter int SAMPLES_PER_MEAN = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_sample_en,
    input  logic [adcvm_pkg::SAMPLE_W-1:0]    i_sample,
    output logic [adcvm_pkg::BCD_W-1:0]       o_bcd
);
    import adcvm_pkg::*;

    localparam int SUM_W  = $clog2(1023 * SAMPLES_PER_MEAN + 1);
    localparam int CNT_W  = $clog2(SAMPLES_PER_MEAN + 1);
    localparam int DIV_SH = SUM_W + $clog2(SAMPLES_PER_MEAN);
    localparam int RECIP  = ((1 << DIV_SH) + SAMPLES_PER_MEAN - 1) / SAMPLES_PER_MEAN;
    localparam int PROD_W = SUM_W + DIV_SH;

    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [BCD_W-1:0]    r_bcd;
    logic [PROD_W-1:0]   mean_prod;
    logic [SAMPLE_W-1:0] mean;
    logic [SCALED_W-1:0] scaled;
    logic [SCALED_W-1:0] quot_sum;
    logic [TENTHS_W-1:0] tenths;
    logic                group_done;

    assign n_sum      = r_sum + SUM_W'(i_sample);
    assign n_cnt      = r_cnt + CNT_W'(1);
    assign group_done = (n_cnt == CNT_W'(SAMPLES_PER_MEAN));

    // The mean is a multiply by the rounded-up reciprocal, exact over the sum's range.
    assign mean_prod = PROD_W'(n_sum) * PROD_W'(RECIP);
    assign mean      = mean_prod[DIV_SH +: SAMPLE_W];

    // Division by 1023 uses x / (2^10 - 1) = (x + (x >> 10) + 1) >> 10 for this range.
    assign scaled   = SCALED_W'(mean) * SCALED_W'(SCALE_NUM) + SCALED_W'(SCALE_ROUND);
    assign quot_sum = scaled + (scaled >> FULL_SH) + SCALED_W'(1);
    assign tenths   = quot_sum[FULL_SH +: TENTHS_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
            r_bcd <= '0;
        end else if (i_sample_en) begin
            if (group_done) begin
                r_sum <= '0;
                r_cnt <= '0;
                r_bcd <= to_bcd(tenths);
            end else begin
                r_sum <= n_sum;
                r_cnt <= n_cnt;
            end
        end
    end

    assign o_bcd = r_bcd;

endmodule

// ----- src/adcvm_display.sv -----
// Digit multiplexer with the result register: picks the digit, looks up its
// segment pattern and drives its enable line. Depends on adcvm_pkg.
`timescale 1ns / 1ps

module adcvm_display (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tick_en,
    input  logic [adcvm_pkg::BCD_W-1:0]   i_bcd,
    input  logic                          i_out_ready,
    output logic                          o_load_ready,
    output logic                          o_out_valid,
    output adcvm_pkg::t_disp_out          o_out
);
    import adcvm_pkg::*;

    logic      r_show_high;
    logic      r_out_valid;
    t_disp_out r_out;
    t_disp_out n_out;
    logic [3:0] digit;

    assign o_load_ready = !r_out_valid || i_out_ready;
    assign digit        = r_show_high ? i_bcd[7:4] : i_bcd[3:0];

    always_comb begin
        n_out.segments      = seg_glyph(digit);
        n_out.low_digit_on  = !r_show_high;
        n_out.high_digit_on = r_show_high;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_show_high <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_tick_en) begin
                r_show_high <= !r_show_high;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- src/adc_average_bcd_display_mux_core.sv -----
// Averaging voltmeter with a two-digit multiplexed seven-segment display.
// An accepted item is held in the input register and is then either
// folded into the running group sum or turned into one display result in the
// output register. One item is accepted per cycle; a refresh tick waits in the
// input register only while the output register holds a result not yet taken.
// Every SAMPLES_PER_MEAN samples, the mean is scaled to tenths of a volt
// (0 to 33) and shown from the next tick on; ticks alternate units and tens.
// Depends on adcvm_pkg, adcvm_average, adcvm_display and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adc_average_bcd_display_mux_core #(
    parameter int SAMPLES_PER_MEAN = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [adcvm_pkg::S_DATA_W-1:0]   s_axis_tdata,  // [9:0] sample, rest zero
    input  logic                             s_axis_tuser,  // [0] kind
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [6:0] segments, [7] low_digit_on, [8] high_digit_on, rest zero
    output logic [adcvm_pkg::M_DATA_W-1:0]   m_axis_tdata
);
    import adcvm_pkg::*;

    logic                r_in_valid;
    logic                r_kind;
    logic [SAMPLE_W-1:0] r_sample;
    logic                advance;
    logic                sample_en;
    logic                tick_en;
    logic                load_ready;
    logic [BCD_W-1:0]    bcd;
    t_disp_out           disp;

    assign sample_en     = r_in_valid && !r_kind;
    assign tick_en       = r_in_valid && r_kind && load_ready;
    assign advance       = sample_en || tick_en;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_kind   <= s_axis_tuser;
            r_sample <= s_axis_tdata[SAMPLE_W-1:0];
        end
    end

    adcvm_average #(
        .SAMPLES_PER_MEAN (SAMPLES_PER_MEAN)
    ) u_average (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_en (sample_en),
        .i_sample    (r_sample),
        .o_bcd       (bcd)
    );

    adcvm_display u_display (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_en    (tick_en),
        .i_bcd        (bcd),
        .i_out_ready  (m_axis_tready),
        .o_load_ready (load_ready),
        .o_out_valid  (m_axis_tvalid),
        .o_out        (disp)
    );

    assign m_axis_tdata = {{(M_DATA_W - SEG_W - 2){1'b0}},
                           disp.high_digit_on, disp.low_digit_on, disp.segments};

    `ASSERT_PROP(a_one_digit_on, m_axis_tvalid |-> $onehot({disp.high_digit_on, disp.low_digit_on}), "exactly one digit enable must be set on a result")
    `ASSERT_NEVER(a_ready_only_when_free, !s_axis_tready && !r_in_valid, "input stalled with an empty input register")
    `ASSERT_PROP(a_tick_held, (r_in_valid && r_kind && m_axis_tvalid && !m_axis_tready) |=> (r_in_valid && r_kind), "stalled refresh tick was lost")
    `ASSERT_PROP(a_digit_alternates, (tick_en && $past(tick_en)) |=> (disp.high_digit_on != $past(disp.high_digit_on)), "consecutive results must alternate digits")

endmodule

// ----- sim/tb_adc_average_bcd_display_mux_core.sv -----
// Self-checking testbench for adc_average_bcd_display_mux_core: a directed table, then random
// samples and refresh ticks with random stalls on both streams, checked against a local model.
// Depends on adcvm_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb_adc_average_bcd_display_mux_core;

    import adcvm_pkg::*;

    localparam bit KIND_SAMPLE = 1'b0;
    localparam bit KIND_TICK   = 1'b1;
    localparam int GROUP_LEN   = 8;
    localparam int RAND_ITEMS  = 750;
    localparam int CALM_ITEMS  = 100;

    localparam logic [SEG_W-1:0] DIGIT_GLYPH [16] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
        7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
    };

    typedef struct packed {
        logic [SEG_W-1:0] segments;
        logic             low_on;
        logic             high_on;
    } t_digit_drive;

    typedef struct packed {
        logic                kind;
        logic [SAMPLE_W-1:0] sample;
        logic                typed;
        t_digit_drive        drive;
    } t_stim_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic                s_axis_tuser = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;

    logic [12:0] group_sum;
    logic [3:0]  group_count;
    logic [7:0]  display_bcd;
    logic        tens_next;

    t_digit_drive pending_digits [$];
    int           mismatches = 0;
    bit           calm = 1'b0;

    t_stim_row directed_rows [24] = '{
        '{KIND_TICK,   10'd0,    1'b1, '{7'h3F, 1'b1, 1'b0}},
        '{KIND_TICK,   10'd0,    1'b1, '{7'h3F, 1'b0, 1'b1}},
        '{KIND_SAMPLE, 10'd1023, 1'b0, '0},
        '{KIND_SAMPLE, 10'd1023, 1'b0, '0},
        '{KIND_SAMPLE, 10'd1023, 1'b0, '0},
        '{KIND_SAMPLE, 10'd1023, 1'b0, '0},
        '{KIND_SAMPLE, 10'd1023, 1'b0, '0},
        '{KIND_SAMPLE, 10'd1023, 1'b0, '0},
        '{KIND_SAMPLE, 10'd1023, 1'b0, '0},
        '{KIND_SAMPLE, 10'd1023, 1'b0, '0},
        '{KIND_TICK,   10'd0,    1'b1, '{7'h4F, 1'b1, 1'b0}},
        '{KIND_TICK,   10'd1023, 1'b1, '{7'h4F, 1'b0, 1'b1}},
        '{KIND_SAMPLE, 10'd0,    1'b0, '0},
        '{KIND_SAMPLE, 10'd1023, 1'b0, '0},
        '{KIND_SAMPLE, 10'd0,    1'b0, '0},
        '{KIND_SAMPLE, 10'd1023, 1'b0, '0},
        '{KIND_SAMPLE, 10'd0,    1'b0, '0},
        '{KIND_SAMPLE, 10'd1023, 1'b0, '0},
        '{KIND_SAMPLE, 10'd0,    1'b0, '0},
        '{KIND_SAMPLE, 10'd1023, 1'b0, '0},
        '{KIND_TICK,   10'h2AA,  1'b0, '0},
        '{KIND_TICK,   10'h155,  1'b0, '0},
        '{KIND_SAMPLE, 10'h2AA,  1'b0, '0},
        '{KIND_TICK,   10'd0,    1'b0, '0}
    };

    adc_average_bcd_display_mux_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic bit advance_voltmeter(input logic kind, input logic [SAMPLE_W-1:0] sample,
                                             output t_digit_drive drive);
        int mean;
        int tenths;
        drive = '0;
        if (kind == KIND_SAMPLE) begin
            group_sum   = group_sum + 13'(sample);
            group_count = group_count + 4'd1;
            if (group_count == 4'(GROUP_LEN)) begin
                mean        = int'(group_sum) / GROUP_LEN;
                tenths      = (mean * 33 + 511) / 1023;
                display_bcd = {4'(tenths / 10), 4'(tenths % 10)};
                group_sum   = '0;
                group_count = '0;
            end
            return 1'b0;
        end
        if (!tens_next) begin
            drive = '{DIGIT_GLYPH[display_bcd[3:0]], 1'b1, 1'b0};
        end else begin
            drive = '{DIGIT_GLYPH[display_bcd[7:4]], 1'b0, 1'b1};
        end
        tens_next = ~tens_next;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch %s: got 0x%0h, expected 0x%0h at %0t", field, got, want, $realtime);
        mismatches++;
    endtask

    task automatic send_item(input logic kind, input logic [SAMPLE_W-1:0] sample,
                             input logic typed, input t_digit_drive typed_drive);
        t_digit_drive drive;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= S_DATA_W'(sample);
        do @(posedge i_clk); while (!s_axis_tready);
        if (advance_voltmeter(kind, sample, drive)) begin
            pending_digits.push_back(typed ? typed_drive : drive);
        end
    endtask

    task automatic idle_sender();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_digit_drive want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_digits.size() == 0) begin
                report_mismatch("unexpected transfer", int'(m_axis_tdata), 0);
            end else begin
                want = pending_digits.pop_front();
                if (m_axis_tdata[6:0] !== want.segments)
                    report_mismatch("segments", int'(m_axis_tdata[6:0]), int'(want.segments));
                if (m_axis_tdata[7] !== want.low_on)
                    report_mismatch("low_digit_on", int'(m_axis_tdata[7]), int'(want.low_on));
                if (m_axis_tdata[8] !== want.high_on)
                    report_mismatch("high_digit_on", int'(m_axis_tdata[8]), int'(want.high_on));
            end
        end
    end

    initial begin
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    initial begin
        int                  level;
        int                  value;
        int                  samples_sent;
        logic                kind;
        logic [SAMPLE_W-1:0] sample;
        group_sum    = '0;
        group_count  = '0;
        display_bcd  = '0;
        tens_next    = 1'b0;
        samples_sent = 0;
        level        = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[r]) begin
            if (r > 4 && $urandom_range(0, 2) == 0) idle_sender();
            send_item(directed_rows[r].kind, directed_rows[r].sample,
                      directed_rows[r].typed, directed_rows[r].drive);
        end
        for (int n = 0; n < RAND_ITEMS; n++) begin
            calm = (n >= RAND_ITEMS - CALM_ITEMS);
            if (n == RAND_ITEMS / 2) begin
                s_axis_tvalid <= 1'b0;
                wait (pending_digits.size() == 0);
                @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                idle_sender();
            end
            kind = ($urandom_range(0, 9) < 4) ? KIND_TICK : KIND_SAMPLE;
            if (kind == KIND_SAMPLE) begin
                if (samples_sent % GROUP_LEN == 0) level = $urandom_range(0, 1023);
                case ($urandom_range(0, 9))
                    0: value = 0;
                    1: value = 1023;
                    2: value = $urandom_range(0, 1023);
                    default: value = level + $urandom_range(0, 64) - 32;
                endcase
                if (value < 0) value = 0;
                if (value > 1023) value = 1023;
                samples_sent++;
            end else begin
                value = $urandom_range(0, 1023);
            end
            sample = SAMPLE_W'(value);
            send_item(kind, sample, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        wait (pending_digits.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_digits.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/adcvm_pkg.sv
src/adcvm_average.sv
src/adcvm_display.sv
src/adc_average_bcd_display_mux_core.sv
sim/tb_adc_average_bcd_display_mux_core.sv
